[src/text_console_grid_assert.svh]
// Assertion macros for the text console grid checker.
// Needs nothing but a clock and an active-low reset in the user's scope.
`ifndef TEXT_CONSOLE_GRID_ASSERT_SVH
`define TEXT_CONSOLE_GRID_ASSERT_SVH

// Same-cycle implication, held off while reset is asserted
`define TCG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, held off while reset is asserted
`define TCG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

[src/tcg_pkg.sv]
// Shared types and constants of the text console grid.
// No dependencies; the RTL files refer to it by scoped names, the bench imports it.
package tcg_pkg;

  // Field widths of the channels and the configuration port
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned ACT_W      = 2;
  localparam int unsigned VROW_W     = 6;
  localparam int unsigned VCOL_W     = 7;
  localparam int unsigned CCOL_W     = 7;
  localparam int unsigned CROW_W     = 6;
  localparam int unsigned GCOLS_W    = 8;
  localparam int unsigned GROWS_W    = 7;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  // Default grid capacity
  localparam int unsigned DEF_MAX_COLS = 128;
  localparam int unsigned DEF_MAX_ROWS = 64;

  // Register reset values
  localparam logic [GCOLS_W-1:0] GRID_COLS_RST = 8'd80;
  localparam logic [GROWS_W-1:0] GRID_ROWS_RST = 7'd25;

  // Character codes with a meaning of their own
  localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [CHAR_W-1:0] NUL_CHAR     = 8'h00;

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE = 2'd0,
    ACT_BACK  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_READ  = 2'd3
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_COLS = 1'b0,
    CFG_GRID_ROWS = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_BLANK,
    ST_FILL,
    ST_RDATA,
    ST_EMIT
  } ctrl_state_e;

endpackage

[src/tcg_stream_if.sv]
// Valid/ready channel interfaces for the console's command and result words.
// Depends on tcg_pkg for field widths and the action type.
interface tcg_in_if;
  logic                               valid;
  logic                               ready;
  tcg_pkg::action_e                   action;
  logic [tcg_pkg::CHAR_W-1:0]         char_code;
  logic [tcg_pkg::VROW_W-1:0]         view_row;
  logic [tcg_pkg::VCOL_W-1:0]         view_col;

  modport source (output valid, action, char_code, view_row, view_col, input ready);
  modport sink   (input valid, action, char_code, view_row, view_col, output ready);
endinterface

interface tcg_out_if;
  logic                               valid;
  logic                               ready;
  logic [tcg_pkg::CHAR_W-1:0]         read_char;
  logic [tcg_pkg::CCOL_W-1:0]         cursor_col;
  logic [tcg_pkg::CROW_W-1:0]         cursor_row;

  modport source (output valid, read_char, cursor_col, cursor_row, input ready);
  modport sink   (input valid, read_char, cursor_col, cursor_row, output ready);
endinterface

[src/tcg_cfg.sv]
// Configuration registers of the console and their clamped grid size.
// Depends on tcg_pkg for widths, reset values and register indexes.
module tcg_cfg #(
  parameter int unsigned MAX_COLS = tcg_pkg::DEF_MAX_COLS,
  parameter int unsigned MAX_ROWS = tcg_pkg::DEF_MAX_ROWS,
  localparam int unsigned CNW = $clog2(MAX_COLS + 1),
  localparam int unsigned RNW = $clog2(MAX_ROWS + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tcg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tcg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic [CNW-1:0]                 eff_cols_o,
  output logic [RNW-1:0]                 eff_rows_o
);

  logic [tcg_pkg::GCOLS_W-1:0] grid_cols_q;
  logic [tcg_pkg::GROWS_W-1:0] grid_rows_q;

  // Take register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_cols_q <= tcg_pkg::GRID_COLS_RST;
      grid_rows_q <= tcg_pkg::GRID_ROWS_RST;
    end else if (cfg_we_i) begin
      unique case (tcg_pkg::cfg_idx_e'(cfg_idx_i))
        tcg_pkg::CFG_GRID_COLS: grid_cols_q <= cfg_data_i[tcg_pkg::GCOLS_W-1:0];
        tcg_pkg::CFG_GRID_ROWS: grid_rows_q <= cfg_data_i[tcg_pkg::GROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the sizes in use to 1..capacity
  always_comb begin
    if (grid_cols_q == '0) begin
      eff_cols_o = CNW'(1);
    end else if (32'(grid_cols_q) > MAX_COLS) begin
      eff_cols_o = CNW'(MAX_COLS);
    end else begin
      eff_cols_o = CNW'(grid_cols_q);
    end

    if (grid_rows_q == '0) begin
      eff_rows_o = RNW'(1);
    end else if (32'(grid_rows_q) > MAX_ROWS) begin
      eff_rows_o = RNW'(MAX_ROWS);
    end else begin
      eff_rows_o = RNW'(grid_rows_q);
    end
  end

endmodule

[src/tcg_cell_mem.sv]
// Character cell store: one write port, one read port, registered read data.
// Depends on tcg_pkg for the character width.
module tcg_cell_mem #(
  parameter int unsigned DEPTH = tcg_pkg::DEF_MAX_COLS * tcg_pkg::DEF_MAX_ROWS,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [tcg_pkg::CHAR_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [tcg_pkg::CHAR_W-1:0] rdata_o
);

  logic [tcg_pkg::CHAR_W-1:0] mem [DEPTH];
  logic [tcg_pkg::CHAR_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/tcg_ctrl.sv]
// Command sequencer: cursor, read-modify-write of the cell store, result register.
// Depends on tcg_pkg and the tcg_in_if / tcg_out_if channel interfaces.
module tcg_ctrl #(
  parameter int unsigned MAX_COLS = tcg_pkg::DEF_MAX_COLS,
  parameter int unsigned MAX_ROWS = tcg_pkg::DEF_MAX_ROWS,
  localparam int unsigned DEPTH = MAX_COLS * MAX_ROWS,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNW   = $clog2(MAX_COLS + 1),
  localparam int unsigned RNW   = $clog2(MAX_ROWS + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  tcg_in_if.sink                     in_if,
  tcg_out_if.source                  out_if,
  input  logic [CNW-1:0]             eff_cols_i,
  input  logic [RNW-1:0]             eff_rows_i,
  output logic                       mem_we_o,
  output logic [AW-1:0]              mem_waddr_o,
  output logic [tcg_pkg::CHAR_W-1:0] mem_wdata_o,
  output logic                       mem_re_o,
  output logic [AW-1:0]              mem_raddr_o,
  input  logic [tcg_pkg::CHAR_W-1:0] mem_rdata_i
);

  localparam int unsigned COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  tcg_pkg::ctrl_state_e state_q, state_d;

  logic [COL_W-1:0]           cur_col_q, cur_col_d;
  logic [ROW_W-1:0]           cur_row_q, cur_row_d;
  logic [AW-1:0]              fill_cnt_q, fill_cnt_d;
  logic [COL_W-1:0]           blank_cnt_q, blank_cnt_d;
  logic [tcg_pkg::CHAR_W-1:0] rd_q, rd_d;
  logic                       out_valid_q, out_valid_d;

  // Held command word
  tcg_pkg::action_e           act_q;
  logic [tcg_pkg::CHAR_W-1:0] ch_q;
  logic [tcg_pkg::VROW_W-1:0] vrow_q;
  logic [tcg_pkg::VCOL_W-1:0] vcol_q;

  // Result word
  logic [tcg_pkg::CHAR_W-1:0] out_char_q;
  logic [COL_W-1:0]           out_col_q;
  logic [ROW_W-1:0]           out_row_q;

  logic take;
  logic load_out;

  logic [COL_W-1:0] col_clamp, bk_col;
  logic [ROW_W-1:0] row_clamp, bk_row, row_down, prow;
  logic [CNW-1:0]   col_inc, blank_inc;
  logic [RNW:0]     prow_sum;
  logic             in_view;

  function automatic logic [AW-1:0] cell_addr(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    return AW'(int'(r) * MAX_COLS + int'(c));
  endfunction

  // Cursor arithmetic shared by the states
  always_comb begin
    col_clamp = (CNW'(cur_col_q) >= eff_cols_i) ? COL_W'(eff_cols_i - CNW'(1)) : cur_col_q;
    row_clamp = (RNW'(cur_row_q) >= eff_rows_i) ? ROW_W'(eff_rows_i - RNW'(1)) : cur_row_q;
    col_inc   = CNW'(cur_col_q) + CNW'(1);
    blank_inc = CNW'(blank_cnt_q) + CNW'(1);
    row_down  = (RNW'(cur_row_q) + RNW'(1) >= eff_rows_i) ? '0 : cur_row_q + ROW_W'(1);

    // Backspace steps back, wrapping up a row and around the top
    if (cur_col_q == '0) begin
      bk_col = COL_W'(eff_cols_i - CNW'(1));
      bk_row = (cur_row_q == '0) ? ROW_W'(eff_rows_i - RNW'(1)) : cur_row_q - ROW_W'(1);
    end else begin
      bk_col = cur_col_q - COL_W'(1);
      bk_row = cur_row_q;
    end

    // View row 0 is the row after the cursor row; sum stays below twice the rows
    in_view  = (int'(vrow_q) < int'(eff_rows_i)) && (int'(vcol_q) < int'(eff_cols_i));
    prow_sum = (RNW+1)'(cur_row_q) + (RNW+1)'(ROW_W'(vrow_q)) + (RNW+1)'(1);
    prow     = (prow_sum >= (RNW+1)'(eff_rows_i)) ?
               ROW_W'(prow_sum - (RNW+1)'(eff_rows_i)) : ROW_W'(prow_sum);
  end

  // Next state and outputs
  always_comb begin
    state_d     = state_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    fill_cnt_d  = fill_cnt_q;
    blank_cnt_d = blank_cnt_q;
    rd_d        = rd_q;
    take        = 1'b0;
    load_out    = 1'b0;
    in_if.ready = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = cell_addr(cur_row_q, cur_col_q);
    mem_wdata_o = tcg_pkg::SPACE_CHAR;
    mem_re_o    = 1'b0;
    mem_raddr_o = cell_addr(prow, COL_W'(vcol_q));

    unique case (state_q)
      tcg_pkg::ST_INIT, tcg_pkg::ST_FILL: begin
        // Sweep every cell of the store to space
        mem_we_o    = 1'b1;
        mem_waddr_o = fill_cnt_q;
        if (fill_cnt_q == AW'(DEPTH - 1)) begin
          state_d = (state_q == tcg_pkg::ST_INIT) ? tcg_pkg::ST_IDLE : tcg_pkg::ST_EMIT;
        end else begin
          fill_cnt_d = fill_cnt_q + AW'(1);
        end
      end

      tcg_pkg::ST_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          take      = 1'b1;
          cur_col_d = col_clamp;
          cur_row_d = row_clamp;
          state_d   = tcg_pkg::ST_EXEC;
        end
      end

      tcg_pkg::ST_EXEC: begin
        rd_d    = tcg_pkg::SPACE_CHAR;
        state_d = tcg_pkg::ST_EMIT;
        unique case (act_q)
          tcg_pkg::ACT_WRITE: begin
            priority if (ch_q == tcg_pkg::NUL_CHAR) begin
              state_d = tcg_pkg::ST_EMIT;
            end else if (ch_q == tcg_pkg::NEWLINE_CHAR) begin
              cur_row_d   = row_down;
              cur_col_d   = '0;
              blank_cnt_d = '0;
              state_d     = tcg_pkg::ST_BLANK;
            end else begin
              mem_we_o    = 1'b1;
              mem_wdata_o = ch_q;
              if (col_inc >= eff_cols_i) begin
                cur_row_d   = row_down;
                cur_col_d   = '0;
                blank_cnt_d = '0;
                state_d     = tcg_pkg::ST_BLANK;
              end else begin
                cur_col_d = cur_col_q + COL_W'(1);
              end
            end
          end
          tcg_pkg::ACT_BACK: begin
            cur_col_d   = bk_col;
            cur_row_d   = bk_row;
            mem_we_o    = 1'b1;
            mem_waddr_o = cell_addr(bk_row, bk_col);
          end
          tcg_pkg::ACT_CLEAR: begin
            cur_col_d  = '0;
            cur_row_d  = '0;
            fill_cnt_d = '0;
            state_d    = tcg_pkg::ST_FILL;
          end
          tcg_pkg::ACT_READ: begin
            if (in_view) begin
              mem_re_o = 1'b1;
              state_d  = tcg_pkg::ST_RDATA;
            end
          end
          default: ;
        endcase
      end

      tcg_pkg::ST_BLANK: begin
        // Blank the new row one column a cycle
        mem_we_o    = 1'b1;
        mem_waddr_o = cell_addr(cur_row_q, blank_cnt_q);
        if (blank_inc >= eff_cols_i) begin
          state_d = tcg_pkg::ST_EMIT;
        end else begin
          blank_cnt_d = blank_cnt_q + COL_W'(1);
        end
      end

      tcg_pkg::ST_RDATA: begin
        rd_d    = mem_rdata_i;
        state_d = tcg_pkg::ST_EMIT;
      end

      tcg_pkg::ST_EMIT: begin
        // Hold until the result register is free
        if (!out_valid_q || out_if.ready) begin
          load_out = 1'b1;
          state_d  = tcg_pkg::ST_IDLE;
        end
      end

      default: state_d = tcg_pkg::ST_INIT;
    endcase

    out_valid_d = load_out | (out_valid_q & ~out_if.ready);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcg_pkg::ST_INIT;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      fill_cnt_q  <= '0;
      blank_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      fill_cnt_q  <= fill_cnt_d;
      blank_cnt_q <= blank_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rd_q <= rd_d;
    if (take) begin
      act_q  <= in_if.action;
      ch_q   <= in_if.char_code;
      vrow_q <= in_if.view_row;
      vcol_q <= in_if.view_col;
    end
    if (load_out) begin
      out_char_q <= rd_q;
      out_col_q  <= cur_col_q;
      out_row_q  <= cur_row_q;
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.read_char  = out_char_q;
  assign out_if.cursor_col = tcg_pkg::CCOL_W'(out_col_q);
  assign out_if.cursor_row = tcg_pkg::CROW_W'(out_row_q);

endmodule

[src/text_console_grid.sv]
// Top level of the text console grid: config registers, sequencer, cell store.
// Depends on tcg_pkg, tcg_stream_if, tcg_cfg, tcg_cell_mem and tcg_ctrl.
//
//   channel   dir  handshake        word
//   in_if     in   valid / ready    action, char_code, view_row, view_col
//   out_if    out  valid / ready    read_char, cursor_col, cursor_row
//   cfg       in   cfg_we_i only    cfg_idx_i, cfg_data_i
//
// A plain write, null, backspace or out-of-view read passes EXEC and then EMIT;
// a view read adds RDATA between them for the registered read of the cell store.
// A write that moves down a row also blanks that row a column at a time in BLANK,
// and clear sweeps every cell in FILL: the store has one write port.
// After reset all MAX_COLS*MAX_ROWS cells (8192 by default) are swept to spaces
// with in_if.ready low; config writes are taken meanwhile.
// A result waits in its register while the next word is accepted.
module text_console_grid #(
  parameter int unsigned MAX_COLS = tcg_pkg::DEF_MAX_COLS,
  parameter int unsigned MAX_ROWS = tcg_pkg::DEF_MAX_ROWS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tcg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tcg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  tcg_in_if.sink                         in_if,
  tcg_out_if.source                      out_if
);

  localparam int unsigned DEPTH = MAX_COLS * MAX_ROWS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNW   = $clog2(MAX_COLS + 1);
  localparam int unsigned RNW   = $clog2(MAX_ROWS + 1);

  logic [CNW-1:0]             eff_cols;
  logic [RNW-1:0]             eff_rows;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [tcg_pkg::CHAR_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;
  logic [tcg_pkg::CHAR_W-1:0] mem_rdata;

  tcg_cfg #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .eff_cols_o (eff_cols),
    .eff_rows_o (eff_rows)
  );

  tcg_cell_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  tcg_ctrl #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .out_if      (out_if),
    .eff_cols_i  (eff_cols),
    .eff_rows_i  (eff_rows),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

endmodule

[src/tcg_checker.sv]
// Port-level checks of the text console grid, bound to the top level.
// Depends on tcg_stream_if and the macros of text_console_grid_assert.svh.
`include "text_console_grid_assert.svh"

module tcg_checker (
  input logic       clk_i,
  input logic       rst_ni,
  tcg_in_if.sink    in_if,
  tcg_out_if.source out_if
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_q;

  assign in_acc  = in_if.valid & in_if.ready;
  assign out_acc = out_if.valid & out_if.ready;

  // Count words accepted and not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  `TCG_ASSERT_NXT(a_out_valid_holds, clk_i, rst_ni, out_if.valid && !out_if.ready, out_if.valid)
  `TCG_ASSERT_NXT(a_out_word_holds, clk_i, rst_ni, out_if.valid && !out_if.ready, $stable(out_if.read_char) && $stable(out_if.cursor_col) && $stable(out_if.cursor_row))
  `TCG_ASSERT_IMP(a_no_extra_result, clk_i, rst_ni, out_acc, pend_q != 2'd0)
  `TCG_ASSERT_IMP(a_two_in_flight_stalls, clk_i, rst_ni, pend_q == 2'd2, !in_if.ready)

endmodule

bind text_console_grid tcg_checker u_tcg_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_if  (in_if),
  .out_if (out_if)
);

[dv/text_console_grid_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for text_console_grid: a scripted opening, then random command words
// over a series of grid sizes. Each result word is checked against its scripted value or a cycle-free console model.
// Depends on tcg_pkg, the tcg_in_if / tcg_out_if channel interfaces and the console RTL.
module text_console_grid_test;
  import tcg_pkg::*;

  localparam int unsigned NCOLS      = DEF_MAX_COLS;
  localparam int unsigned NROWS      = DEF_MAX_ROWS;
  localparam int unsigned RAND_WORDS = 900;
  localparam int unsigned PHASES     = 10;
  localparam int unsigned SCRIPT_LEN = 22;

  // One result word: character read back and cursor position after the command
  typedef struct packed {
    logic [CHAR_W-1:0] rd;
    logic [CCOL_W-1:0] col;
    logic [CROW_W-1:0] row;
  } status_t;

  typedef struct {
    action_e           act;
    logic [CHAR_W-1:0] ch;
    logic [VROW_W-1:0] vr;
    logic [VCOL_W-1:0] vc;
    bit                typed;
    status_t           want;
  } script_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  tcg_in_if  cmd_ch ();
  tcg_out_if rsp_ch ();

  text_console_grid u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (cmd_ch),
    .out_if     (rsp_ch)
  );

  always #5 clk_i = ~clk_i;

  // Console model state
  logic [CHAR_W-1:0]  shadow_grid [NCOLS*NROWS];
  int unsigned        crs_col;
  int unsigned        crs_row;
  logic [GCOLS_W-1:0] set_cols;
  logic [GROWS_W-1:0] set_rows;

  status_t due_words[$];
  int      err_count = 0;
  bit      calm = 1'b0;

  function automatic int unsigned eff_cols();
    if (set_cols == 0) return 1;
    if (set_cols > NCOLS) return NCOLS;
    return 32'(set_cols);
  endfunction

  function automatic int unsigned eff_rows();
    if (set_rows == 0) return 1;
    if (set_rows > NROWS) return NROWS;
    return 32'(set_rows);
  endfunction

  // Move down one row of the ring, home the column and blank the row entered
  task automatic step_down(input int unsigned cols, input int unsigned rows);
    if (crs_row + 1 >= rows) crs_row = 0;
    else crs_row++;
    for (int unsigned c = 0; c < cols; c++) shadow_grid[crs_row*NCOLS + c] = SPACE_CHAR;
    crs_col = 0;
  endtask

  // Apply one command word to the model and return the word it should produce
  task automatic console_step(input action_e act, input logic [CHAR_W-1:0] ch,
                              input logic [VROW_W-1:0] vr, input logic [VCOL_W-1:0] vc,
                              output status_t res);
    int unsigned       cols;
    int unsigned       rows;
    int unsigned       prow;
    logic [CHAR_W-1:0] rd;
    cols = eff_cols();
    rows = eff_rows();
    rd   = SPACE_CHAR;
    // pull a cursor left outside a shrunk grid back to its edge
    if (crs_col >= cols) crs_col = cols - 1;
    if (crs_row >= rows) crs_row = rows - 1;
    case (act)
      ACT_WRITE: begin
        if (ch == NEWLINE_CHAR) begin
          step_down(cols, rows);
        end else if (ch != NUL_CHAR) begin
          shadow_grid[crs_row*NCOLS + crs_col] = ch;
          if (crs_col + 1 >= cols) step_down(cols, rows);
          else crs_col++;
        end
      end
      ACT_BACK: begin
        if (crs_col == 0) begin
          crs_col = cols - 1;
          crs_row = (crs_row == 0) ? rows - 1 : crs_row - 1;
        end else begin
          crs_col--;
        end
        shadow_grid[crs_row*NCOLS + crs_col] = SPACE_CHAR;
      end
      ACT_CLEAR: begin
        foreach (shadow_grid[i]) shadow_grid[i] = SPACE_CHAR;
        crs_col = 0;
        crs_row = 0;
      end
      ACT_READ: begin
        // view row 0 is the oldest row, the one after the cursor's row
        if (vr < rows && vc < cols) begin
          prow = (crs_row + 1 + vr) % rows;
          rd   = shadow_grid[prow*NCOLS + vc];
        end
      end
    endcase
    res = '{rd, crs_col[CCOL_W-1:0], crs_row[CROW_W-1:0]};
  endtask

  // Offer one command word after a random gap; log its expected result once taken
  task automatic send_word(input action_e act, input logic [CHAR_W-1:0] ch,
                           input logic [VROW_W-1:0] vr, input logic [VCOL_W-1:0] vc,
                           input bit typed, input status_t want);
    int unsigned gap;
    status_t     res;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.action    <= act;
    cmd_ch.char_code <= ch;
    cmd_ch.view_row  <= vr;
    cmd_ch.view_col  <= vc;
    do @(posedge clk_i); while (!cmd_ch.ready);
    console_step(act, ch, vr, vc, res);
    due_words.push_back(typed ? want : res);
  endtask

  // Drop valid and hold until every expected word is back and the block is quiet
  task automatic settle();
    cmd_ch.valid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // Stimulus: scripted opening at reset geometry, then random words per grid setting
  initial begin : stimulus
    script_row_t       script [SCRIPT_LEN];
    logic [7:0]        phase_cols [PHASES];
    logic [7:0]        phase_rows [PHASES];
    action_e           act;
    logic [CHAR_W-1:0] ch;
    logic [VROW_W-1:0] vr;
    logic [VCOL_W-1:0] vc;
    int unsigned       pick;
    int unsigned       clears_left;

    cmd_ch.valid     = 1'b0;
    cmd_ch.action    = ACT_WRITE;
    cmd_ch.char_code = '0;
    cmd_ch.view_row  = '0;
    cmd_ch.view_col  = '0;
    foreach (shadow_grid[i]) shadow_grid[i] = SPACE_CHAR;
    crs_col     = 0;
    crs_row     = 0;
    set_cols    = GRID_COLS_RST;
    set_rows    = GRID_ROWS_RST;
    clears_left = 25;

    // 80 x 25 grid out of reset
    script = '{
      '{ACT_READ,  8'h00,        6'd0,  7'd0,   1'b1, '{8'h20, 7'd0,  6'd0}},
      '{ACT_READ,  8'hFF,        6'd63, 7'd127, 1'b1, '{8'h20, 7'd0,  6'd0}},
      '{ACT_WRITE, 8'h41,        6'd0,  7'd0,   1'b1, '{8'h20, 7'd1,  6'd0}},
      '{ACT_WRITE, NUL_CHAR,     6'd0,  7'd0,   1'b1, '{8'h20, 7'd1,  6'd0}},
      '{ACT_WRITE, 8'hFF,        6'd63, 7'd127, 1'b1, '{8'h20, 7'd2,  6'd0}},
      '{ACT_READ,  8'h00,        6'd24, 7'd0,   1'b1, '{8'h41, 7'd2,  6'd0}},
      '{ACT_READ,  8'h00,        6'd24, 7'd1,   1'b1, '{8'hFF, 7'd2,  6'd0}},
      '{ACT_BACK,  8'h00,        6'd0,  7'd0,   1'b1, '{8'h20, 7'd1,  6'd0}},
      '{ACT_READ,  8'h00,        6'd24, 7'd1,   1'b1, '{8'h20, 7'd1,  6'd0}},
      '{ACT_BACK,  8'h00,        6'd0,  7'd0,   1'b1, '{8'h20, 7'd0,  6'd0}},
      '{ACT_BACK,  8'hFF,        6'd63, 7'd127, 1'b1, '{8'h20, 7'd79, 6'd24}},
      '{ACT_WRITE, 8'h7E,        6'd0,  7'd0,   1'b1, '{8'h20, 7'd0,  6'd0}},
      '{ACT_READ,  8'h00,        6'd23, 7'd79,  1'b1, '{8'h7E, 7'd0,  6'd0}},
      '{ACT_WRITE, NEWLINE_CHAR, 6'd0,  7'd0,   1'b1, '{8'h20, 7'd0,  6'd1}},
      '{ACT_WRITE, 8'h55,        6'd0,  7'd0,   1'b0, '0},
      '{ACT_WRITE, 8'hAA,        6'd0,  7'd0,   1'b0, '0},
      '{ACT_READ,  8'h00,        6'd22, 7'd79,  1'b0, '0},
      '{ACT_READ,  8'h00,        6'd24, 7'd80,  1'b1, '{8'h20, 7'd2,  6'd1}},
      '{ACT_CLEAR, 8'hFF,        6'd63, 7'd127, 1'b1, '{8'h20, 7'd0,  6'd0}},
      '{ACT_READ,  8'h00,        6'd22, 7'd79,  1'b1, '{8'h20, 7'd0,  6'd0}},
      '{ACT_READ,  8'h00,        6'd0,  7'd0,   1'b0, '0},
      '{ACT_WRITE, 8'h80,        6'd0,  7'd0,   1'b0, '0}
    };

    // Grid settings per phase, out-of-range values included (rows 130 keeps 7 bits)
    phase_cols = '{8'd128, 8'd5, 8'd1, 8'd0, 8'd255, 8'd17, 8'd128, 8'd3, 8'd40, 8'd80};
    phase_rows = '{8'd64,  8'd3, 8'd1, 8'd0, 8'd130, 8'd9,  8'd2,   8'd64, 8'd12, 8'd25};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i])
      send_word(script[i].act, script[i].ch, script[i].vr, script[i].vc,
                script[i].typed, script[i].want);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      // load both grid registers back to back
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CFG_GRID_COLS;
      cfg_data_i <= phase_cols[p];
      set_cols    = phase_cols[p][GCOLS_W-1:0];
      @(posedge clk_i);
      cfg_idx_i  <= CFG_GRID_ROWS;
      cfg_data_i <= phase_rows[p];
      set_rows    = phase_rows[p][GROWS_W-1:0];
      @(posedge clk_i);
      cfg_we_i   <= 1'b0;

      for (int k = 0; k < RAND_WORDS / PHASES; k++) begin
        if (k % 30 == 0) calm = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 99);
        act  = ACT_WRITE;
        ch   = CHAR_W'($urandom_range(0, 255));
        vr   = VROW_W'($urandom_range(0, 63));
        vc   = VCOL_W'($urandom_range(0, 127));
        if (pick < 2 && clears_left != 0) begin
          act = ACT_CLEAR;
          clears_left--;
        end else if (pick < 45) begin
          act = ACT_WRITE;
        end else if (pick < 52) begin
          ch = NEWLINE_CHAR;
        end else if (pick < 54) begin
          ch = NUL_CHAR;
        end else if (pick < 66) begin
          act = ACT_BACK;
        end else begin
          act = ACT_READ;
          // mostly aim inside the view so written cells get read back
          if ($urandom_range(0, 4) != 0) begin
            vr = VROW_W'($urandom_range(0, eff_rows() - 1));
            vc = VCOL_W'($urandom_range(0, eff_cols() - 1));
          end
        end
        send_word(act, ch, vr, vc, 1'b0, '0);
      end
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (err_count == 0 && due_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Result side: stall at random, compare each word with the oldest expectation
  initial begin : result_sink
    int unsigned stall;
    status_t     got;
    status_t     want;
    rsp_ch.ready = 1'b0;
    @(posedge clk_i);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_ch.valid);
      got = '{rsp_ch.read_char, rsp_ch.cursor_col, rsp_ch.cursor_row};
      if (due_words.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected word: read_char %h col %0d row %0d",
                   got.rd, got.col, got.row);
      end else begin
        want = due_words.pop_front();
        if (got.rd !== want.rd || got.col !== want.col || got.row !== want.row) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: read_char exp %h got %h, col exp %0d got %0d, %s %0d got %0d",
                     want.rd, got.rd, want.col, got.col, "row exp", want.row, got.row);
        end
      end
    end
  end

  // Hold the run to a fixed budget well above the slowest legal run
  initial begin : watchdog
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/tcg_pkg.sv
src/tcg_stream_if.sv
src/tcg_cfg.sv
src/tcg_cell_mem.sv
src/tcg_ctrl.sv
src/text_console_grid.sv
src/tcg_checker.sv
dv/text_console_grid_test.sv
